@@ sv/fadr_pkg.sv @@
// Shared constants, types and codes for the framed ASCII decimal reader.
`default_nettype none
package fadr_pkg;

  // Frame geometry
  localparam int FRAME_BYTES = 9;
  localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
  localparam int BYTE_W      = 8;

  // Result widths and limits
  localparam int VALUE_W = 30;
  localparam int INT_W   = 27;
  localparam int DIGIT_W = 4;
  localparam logic [VALUE_W-1:0] VALUE_MAX = VALUE_W'(999999990);
  localparam logic [VALUE_W-1:0] INT_CAP   = VALUE_W'(100000000);

  // Configuration register indexes and reset values
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL = 1'd1;
  localparam logic [BYTE_W-1:0] HEAD_RESET = 8'h4F;
  localparam logic [BYTE_W-1:0] TAIL_RESET = 8'h0A;

  // ASCII characters the parser looks for
  localparam logic [BYTE_W-1:0] CHAR_0   = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_9   = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_DOT = 8'h2E;

  // Byte feed from the controller into the parser
  typedef struct packed {
    logic              start;
    logic              feed;
    logic [BYTE_W-1:0] data;
  } parse_ctl_t;

  // Parser outcome
  typedef struct packed {
    logic               found;
    logic [VALUE_W-1:0] tenths;
  } parse_res_t;

endpackage : fadr_pkg
`default_nettype wire

@@ sv/fadr_cell.sv @@
// One byte cell of the frame shift chain.
`default_nettype none
module fadr_cell
  import fadr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              shift_en,
  input  wire logic [BYTE_W-1:0] d_in,
  output logic      [BYTE_W-1:0] q
);

  logic [BYTE_W-1:0] data_r;
  logic [BYTE_W-1:0] data_nxt;

  // Take the neighbor's byte on a shift, else hold
  always_comb begin
    data_nxt = shift_en ? d_in : data_r;
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule : fadr_cell
`default_nettype wire

@@ sv/fadr_parser.sv @@
// Byte-serial decimal parser: one byte per cycle, result in tenths.
`default_nettype none
module fadr_parser
  import fadr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire parse_ctl_t ctl,
  output parse_res_t      res
);

  typedef enum logic [1:0] {
    P_SCAN,
    P_INT,
    P_DOT,
    P_END
  } pstate_t;

  pstate_t             pstate_r, pstate_nxt;
  logic [INT_W-1:0]    ip_r, ip_nxt;
  logic [DIGIT_W-1:0]  frac_r, frac_nxt;
  logic                found_r, found_nxt;

  logic                is_dig;
  logic [DIGIT_W-1:0]  dig;
  logic [VALUE_W-1:0]  ip_x10;
  logic [VALUE_W-1:0]  ip_acc;
  logic [VALUE_W-1:0]  total;

  // Digit decode
  assign is_dig = (ctl.data >= CHAR_0) && (ctl.data <= CHAR_9);
  assign dig    = DIGIT_W'(ctl.data - CHAR_0);

  // Integer accumulate with cap: ip*10 + d
  assign ip_x10 = (VALUE_W'(ip_r) << 3) + (VALUE_W'(ip_r) << 1);
  assign ip_acc = ip_x10 + VALUE_W'(dig);

  // Parse step
  always_comb begin
    pstate_nxt = pstate_r;
    ip_nxt     = ip_r;
    frac_nxt   = frac_r;
    found_nxt  = found_r;
    if (ctl.start) begin
      pstate_nxt = P_SCAN;
      ip_nxt     = '0;
      frac_nxt   = '0;
      found_nxt  = 1'b0;
    end else if (ctl.feed) begin
      unique case (pstate_r)
        P_SCAN: begin
          if (is_dig) begin
            ip_nxt     = INT_W'(dig);
            found_nxt  = 1'b1;
            pstate_nxt = P_INT;
          end
        end
        P_INT: begin
          if (is_dig) begin
            ip_nxt = (ip_acc > INT_CAP) ? INT_W'(INT_CAP) : INT_W'(ip_acc);
          end else if (ctl.data == CHAR_DOT) begin
            pstate_nxt = P_DOT;
          end else begin
            pstate_nxt = P_END;
          end
        end
        P_DOT: begin
          if (is_dig) begin
            frac_nxt = dig;
          end
          pstate_nxt = P_END;
        end
        default: begin
          pstate_nxt = P_END;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pstate_r <= P_SCAN;
      found_r  <= 1'b0;
    end else begin
      pstate_r <= pstate_nxt;
      found_r  <= found_nxt;
    end
    ip_r   <= ip_nxt;
    frac_r <= frac_nxt;
  end

  // Tenths with saturation; zero when no digit was seen
  always_comb begin
    total = ip_x10 + VALUE_W'(frac_r);
    if (total > VALUE_MAX) begin
      total = VALUE_MAX;
    end
    res.found  = found_r;
    res.tenths = found_r ? total : '0;
  end

endmodule : fadr_parser
`default_nettype wire

@@ sv/framed_ascii_decimal_reader.sv @@
// Framed ASCII decimal reader top level: frame chain, control and result register.
// Sequence: a full-frame tail byte starts a parse in S_RUN; S_DONE then loads the result register.
// Throughput: input is taken only in S_IDLE; a parsing tail holds off input until the result is
//   loaded, the frame chain rotating one byte per cycle into the byte-serial parser.
// Reset (rst_n low, synchronous): frame empty, head 0x4F, tail 0x0A, no result pending.
// Frame bytes themselves are not cleared; only full frames are ever read.
`default_nettype none
module framed_ascii_decimal_reader
  import fadr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration write port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_wdata,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [BYTE_W-1:0]    in_rx_byte,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [VALUE_W-1:0]        out_value_tenths,
  output logic                      out_had_digit
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     fill_r, fill_nxt;
  logic [CNT_W-1:0]     step_r, step_nxt;
  logic [BYTE_W-1:0]    head_r, tail_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]   value_r, value_nxt;
  logic                 had_r, had_nxt;

  logic                 acc;
  logic                 is_head, is_tail, do_append, do_parse;
  logic                 rotate;
  logic                 shift_en;
  logic [BYTE_W-1:0]    chain_in;
  logic [BYTE_W-1:0]    cell_q [FRAME_BYTES];
  parse_ctl_t           pctl;
  parse_res_t           pres;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= HEAD_RESET;
      tail_r <= TAIL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEAD: head_r <= cfg_wdata;
        CFG_TAIL: tail_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Byte classification on an accepted transaction
  assign in_ready  = (state_r == S_IDLE);
  assign acc       = in_valid && in_ready;
  assign is_head   = (in_rx_byte == head_r);
  assign is_tail   = !is_head && (in_rx_byte == tail_r);
  assign do_append = acc && !is_head && !is_tail && (fill_r != '0) &&
                     (fill_r < CNT_W'(FRAME_BYTES));
  assign do_parse  = acc && is_tail && (fill_r == CNT_W'(FRAME_BYTES));

  // Frame chain: shift in on head/append, rotate while parsing
  assign rotate   = (state_r == S_RUN) && (step_r < CNT_W'(FRAME_BYTES));
  assign shift_en = (acc && is_head) || do_append || rotate;
  assign chain_in = rotate ? cell_q[0] : in_rx_byte;

  for (genvar i = 0; i < FRAME_BYTES; i++) begin : g_cell
    logic [BYTE_W-1:0] d;
    if (i == FRAME_BYTES - 1) begin : g_last
      assign d = chain_in;
    end else begin : g_mid
      assign d = cell_q[i+1];
    end
    fadr_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .d_in     (d),
      .q        (cell_q[i])
    );
  end

  // Parser feed: stored bytes in order, then the tail byte
  always_comb begin
    pctl.start = do_parse;
    pctl.feed  = (state_r == S_RUN);
    pctl.data  = rotate ? cell_q[0] : tail_r;
  end

  fadr_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (pctl),
    .res   (pres)
  );

  // Control sequencing and result register
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    value_nxt     = value_r;
    had_nxt       = had_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (acc && is_head) begin
          fill_nxt = CNT_W'(1);
        end else if (do_append) begin
          fill_nxt = fill_r + CNT_W'(1);
        end
        if (do_parse) begin
          step_nxt  = '0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        step_nxt = step_r + CNT_W'(1);
        if (step_r == CNT_W'(FRAME_BYTES)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          value_nxt     = pres.tenths;
          had_nxt       = pres.found;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    value_r <= value_nxt;
    had_r   <= had_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_value_tenths = value_r;
  assign out_had_digit    = had_r;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(FRAME_BYTES))
    else $error("fill count beyond frame size");

  a_parse_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    do_parse |=> !in_ready)
    else $error("input still open after a parse started");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the finish step");

  a_no_digit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !had_r) |-> (value_r == '0))
    else $error("nonzero value without a digit");

endmodule : framed_ascii_decimal_reader
`default_nettype wire
